// File: hdl/cbsm_pkg.sv
// ----------------------------------------------------------------------------
// cbsm_pkg
// Shared types and constants for the cartridge bank switch mapper.
// ----------------------------------------------------------------------------
package cbsm_pkg;

    localparam int CHR_SLOTS = 8;
    localparam int PRG_SLOTS = 4;

    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 8;
    localparam int ROM_W     = 22;
    localparam int PRG_CNT_W = 9;
    localparam int CHR_CNT_W = 11;
    localparam int CHR_PAGE_W = 8;
    localparam int CFG_W     = CHR_CNT_W;
    localparam int CFG_IDX_W = 1;

    // Remainder unit: dividend is one data byte, divisor is the wider page count.
    localparam int DIV_DVD_W = DATA_W;
    localparam int DIV_DSR_W = CHR_CNT_W;
    localparam int DIV_CNT_W = $clog2(DIV_DVD_W);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_CPU   = 2'd1,
        OP_PPU   = 2'd2,
        OP_SPARE = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRG_COUNT = 1'b0,
        CFG_CHR_COUNT = 1'b1
    } cfg_idx_t;

    localparam logic [ADDR_W-1:0] ADDR_CHR_PAIR0 = 16'h7EF0;
    localparam logic [ADDR_W-1:0] ADDR_CHR_PAIR1 = 16'h7EF1;
    localparam logic [ADDR_W-1:0] ADDR_CHR_ONE_LO = 16'h7EF2;
    localparam logic [ADDR_W-1:0] ADDR_CHR_ONE_HI = 16'h7EF5;
    localparam logic [ADDR_W-1:0] ADDR_MIRROR    = 16'h7EF6;
    localparam logic [ADDR_W-1:0] ADDR_PRG_LO    = 16'h7EFA;
    localparam logic [ADDR_W-1:0] ADDR_PRG_HI    = 16'h7EFF;

    localparam logic [DATA_W-1:0] CHR_PAIR_MASK = 8'h7F;

    localparam logic [PRG_CNT_W-1:0] PRG_COUNT_RESET = 9'd2;
    localparam logic [CHR_CNT_W-1:0] CHR_COUNT_RESET = 11'd8;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } in_item_t;

    typedef struct packed {
        logic [ROM_W-1:0] rom_address;
        logic             mapped;
        logic             vertical_mirroring;
    } out_item_t;

    typedef struct packed {
        logic busy;
        logic last;
    } rem_status_t;

endpackage

// File: hdl/cbsm_rem_unit.sv
// ----------------------------------------------------------------------------
// cbsm_rem_unit
// Restoring remainder unit: one dividend bit per cycle, one compare-subtract.
// ----------------------------------------------------------------------------
module cbsm_rem_unit
    import cbsm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_DVD_W-1:0] dividend,
    input  logic [DIV_DSR_W-1:0] divisor,
    output rem_status_t          status,
    output logic [DIV_DVD_W-1:0] remainder
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic [DIV_DVD_W-1:0] rem_reg, rem_next;
    logic [DIV_DVD_W-1:0] dvd_reg, dvd_next;
    logic [DIV_DSR_W-1:0] dsr_reg, dsr_next;

    logic [DIV_DVD_W:0]   shifted;
    logic [DIV_DSR_W:0]   trial;

    always_comb
    begin
        shifted    = {rem_reg, dvd_reg[DIV_DVD_W-1]};
        trial      = {{(DIV_DSR_W-DIV_DVD_W){1'b0}}, shifted} - {1'b0, dsr_reg};
        busy_next  = busy_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        dsr_next   = dsr_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = '0;
            dvd_next   = dividend;
            dsr_next   = divisor;
        end
        else if (busy_reg)
        begin
            // Keep the shifted value unless the divisor fits.
            if (trial[DIV_DSR_W])
                rem_next = shifted[DIV_DVD_W-1:0];
            else
                rem_next = trial[DIV_DVD_W-1:0];
            dvd_next   = {dvd_reg[DIV_DVD_W-2:0], 1'b0};
            count_next = count_reg + 1'b1;
            if (count_reg == DIV_CNT_W'(DIV_DVD_W - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign status.busy = busy_reg;
    assign status.last = busy_reg && (count_reg == DIV_CNT_W'(DIV_DVD_W - 1));
    assign remainder   = rem_reg;

endmodule

// File: hdl/cartridge_bank_switch_mapper.sv
// ----------------------------------------------------------------------------
// cartridge_bank_switch_mapper
// Bank register file, write decode and address translation for a cartridge.
// ----------------------------------------------------------------------------
// One item is taken at a time. A translate item moves from acceptance to the
// emit state, which registers its result into the output register and then
// returns to idle, where the next item can be accepted. A bank register write
// that needs a page reduction passes through the remainder state first. The
// shared remainder unit sets how long that state lasts: it is loaded at
// acceptance, retires one data bit per cycle over the 8 bits of the written
// byte, and the emit state then hands the result over. Writes that need no
// reduction (mirroring, unknown addresses, ignored writes when a page count is
// zero) take as long as a translate. The result sits in an output register,
// so the next item is accepted while a finished result still waits; the block
// only stalls if a second result is ready before the first is taken.
// Configuration writes (page counts) are always taken; writing the PRG page
// count also reloads the third switchable PRG slot with the count minus two.
// ----------------------------------------------------------------------------
module cartridge_bank_switch_mapper
    import cbsm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    typedef enum logic [2:0] {
        WR_NONE     = 3'd0,
        WR_CHR_PAIR = 3'd1,
        WR_CHR_ONE  = 3'd2,
        WR_MIRROR   = 3'd3,
        WR_PRG      = 3'd4
    } wr_kind_t;

    localparam int CHR_IDX_W = $clog2(CHR_SLOTS);
    localparam int PRG_IDX_W = $clog2(PRG_SLOTS);

    state_t   state_reg, state_next;
    in_item_t item_reg;
    wr_kind_t kind_reg, kind_next;

    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_item_reg, out_item_next;

    logic [PRG_CNT_W-1:0]  prg_cnt_reg;
    logic [CHR_CNT_W-1:0]  chr_cnt_reg;
    logic [CHR_PAGE_W-1:0] chr_bank_reg [CHR_SLOTS];
    logic [PRG_CNT_W-1:0]  prg_bank_reg [PRG_SLOTS-1];
    logic                  mirror_reg;

    logic                 accept;
    logic                 emit_fire;
    logic                 div_start;
    logic [DIV_DVD_W-1:0] div_dividend;
    logic [DIV_DSR_W-1:0] div_divisor;
    rem_status_t          div_status;
    logic [DIV_DVD_W-1:0] div_rem;

    logic [CHR_PAGE_W-1:0] pair_lo;
    logic [CHR_PAGE_W:0]   pair_inc;
    logic [CHR_PAGE_W-1:0] pair_hi;
    logic [CHR_IDX_W-1:0]  pair_base;
    logic [CHR_IDX_W-1:0]  one_slot;
    logic [1:0]            prg_slot;
    logic [PRG_CNT_W-1:0]  cpu_page;
    logic                  mirror_after;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    // Decode the incoming write; a zero page count turns the write into a no-op.
    always_comb
    begin
        kind_next = WR_NONE;
        if (in_item.op == OP_WRITE)
        begin
            priority if (in_item.addr == ADDR_CHR_PAIR0 || in_item.addr == ADDR_CHR_PAIR1)
                kind_next = (chr_cnt_reg != '0) ? WR_CHR_PAIR : WR_NONE;
            else if (in_item.addr >= ADDR_CHR_ONE_LO && in_item.addr <= ADDR_CHR_ONE_HI)
                kind_next = (chr_cnt_reg != '0) ? WR_CHR_ONE : WR_NONE;
            else if (in_item.addr == ADDR_MIRROR)
                kind_next = WR_MIRROR;
            else if (in_item.addr >= ADDR_PRG_LO && in_item.addr <= ADDR_PRG_HI)
                kind_next = (prg_cnt_reg != '0) ? WR_PRG : WR_NONE;
            else
                kind_next = WR_NONE;
        end
    end

    // Launch the remainder unit straight from the accepted item.
    always_comb
    begin
        div_start    = accept && (kind_next == WR_CHR_PAIR || kind_next == WR_CHR_ONE
                                  || kind_next == WR_PRG);
        div_dividend = (kind_next == WR_CHR_PAIR) ? (in_item.data & CHR_PAIR_MASK)
                                                  : in_item.data;
        div_divisor  = (kind_next == WR_PRG) ? DIV_DSR_W'(prg_cnt_reg) : chr_cnt_reg;
    end

    cbsm_rem_unit u_rem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .status    (div_status),
        .remainder (div_rem)
    );

    // Sequencer: idle, iterate the remainder for a reducing write, then hand the item's result over.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = div_start ? ST_DIV : ST_EMIT;
            ST_DIV:
                if (div_status.last)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (emit_fire)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Slot arithmetic for the write being retired.
    always_comb
    begin
        pair_lo   = div_rem;
        pair_inc  = {1'b0, div_rem} + 1'b1;
        // v is below the count, so v+1 wraps only when it meets the count.
        pair_hi   = (CHR_CNT_W'(pair_inc) == chr_cnt_reg) ? '0 : pair_inc[CHR_PAGE_W-1:0];
        pair_base = item_reg.addr[0] ? CHR_IDX_W'(2) : CHR_IDX_W'(0);
        one_slot  = item_reg.addr[CHR_IDX_W-1:0] + CHR_IDX_W'(2);
        prg_slot  = item_reg.addr[2:1] - 2'd1;
        mirror_after = (kind_reg == WR_MIRROR) ? item_reg.data[0] : mirror_reg;
    end

    // Build the result from the item and the current bank state.
    always_comb
    begin
        cpu_page = '0;
        unique case (item_reg.addr[ADDR_W-2 -: PRG_IDX_W])
            2'd0:    cpu_page = prg_bank_reg[0];
            2'd1:    cpu_page = prg_bank_reg[1];
            2'd2:    cpu_page = prg_bank_reg[2];
            default: cpu_page = prg_cnt_reg - 1'b1;
        endcase

        out_item_next.rom_address        = '0;
        out_item_next.mapped             = 1'b0;
        out_item_next.vertical_mirroring = mirror_after;
        unique case (item_reg.op)
            OP_CPU:
                if (item_reg.addr[ADDR_W-1])
                begin
                    out_item_next.rom_address = {cpu_page, item_reg.addr[12:0]};
                    out_item_next.mapped      = 1'b1;
                end
            OP_PPU:
                if (item_reg.addr[15:13] == 3'd0 && chr_cnt_reg != '0)
                begin
                    out_item_next.rom_address = ROM_W'({chr_bank_reg[item_reg.addr[12:10]],
                                                        item_reg.addr[9:0]});
                    out_item_next.mapped      = 1'b1;
                end
            default:
                out_item_next.mapped = 1'b0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (emit_fire)
            out_valid_next = 1'b1;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            kind_reg      <= WR_NONE;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (accept)
                kind_reg <= kind_next;
        end
    end

    // Payload: hold the accepted item and the offered result.
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_item;
        if (emit_fire)
            out_item_reg <= out_item_next;
    end

    // Bank state: page counts, slots and mirroring.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_cnt_reg <= PRG_COUNT_RESET;
            chr_cnt_reg <= CHR_COUNT_RESET;
            for (int i = 0; i < CHR_SLOTS; i++)
                chr_bank_reg[i] <= CHR_PAGE_W'(i);
            prg_bank_reg[0] <= PRG_CNT_W'(0);
            prg_bank_reg[1] <= PRG_CNT_W'(1);
            prg_bank_reg[2] <= PRG_COUNT_RESET - PRG_CNT_W'(2);
            mirror_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_PRG_COUNT:
                    begin
                        prg_cnt_reg     <= cfg_data[PRG_CNT_W-1:0];
                        prg_bank_reg[2] <= cfg_data[PRG_CNT_W-1:0] - PRG_CNT_W'(2);
                    end
                    CFG_CHR_COUNT:
                        chr_cnt_reg <= cfg_data;
                    default:
                        chr_cnt_reg <= chr_cnt_reg;
                endcase
            end
            if (emit_fire)
            begin
                unique case (kind_reg)
                    WR_CHR_PAIR:
                    begin
                        chr_bank_reg[pair_base]        <= pair_lo;
                        chr_bank_reg[pair_base + 1'b1] <= pair_hi;
                    end
                    WR_CHR_ONE:
                        chr_bank_reg[one_slot] <= div_rem;
                    WR_MIRROR:
                        mirror_reg <= item_reg.data[0];
                    WR_PRG:
                        prg_bank_reg[prg_slot] <= PRG_CNT_W'(div_rem);
                    default:
                        mirror_reg <= mirror_reg;
                endcase
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: sim/cartridge_bank_switch_mapper_tb.sv
// ----------------------------------------------------------------------------
// cartridge_bank_switch_mapper_tb
// Self-checking regression for the cartridge bank switch mapper. Bank writes,
// CPU and PPU translates and stray items are sent over the input channel and
// mirrored in a local bank map. Each result is compared with the bank map's
// answer. Page counts change between phases, and both channel ends idle and
// stall at random.
// ----------------------------------------------------------------------------
module cartridge_bank_switch_mapper_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cbsm_pkg::*;

    // Bus windows that translate; anything outside answers unmapped.
    localparam logic [ADDR_W-1:0] CPU_ROM_BASE = 16'h8000;
    localparam logic [ADDR_W-1:0] PPU_CHR_TOP  = 16'h2000;

    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
    localparam int TAIL_CYCLES   = 20;     // settle time after the final drain
    localparam int CYCLE_LIMIT   = 200000; // watchdog bound for the whole run
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASES        = 9;
    localparam int ITEMS_A_PHASE = 128;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             in_item;
    logic                 out_valid;
    logic                 out_ready;
    out_item_t            out_item;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // Local copy of the bank map: page counts, slot pages and mirroring.
    logic [PRG_CNT_W-1:0]  prg_pages;
    logic [CHR_CNT_W-1:0]  chr_pages;
    logic [CHR_PAGE_W-1:0] chr_sel [CHR_SLOTS];
    logic [PRG_CNT_W-1:0]  prg_sel [PRG_SLOTS-1];
    logic                  mirror_v;

    // Translations accepted by the block and not yet returned, oldest first.
    out_item_t awaited_maps [$];

    int unsigned mismatch_count;
    int unsigned cycle_count;

    // Idling switches, flipped per phase so that some stretches run flat out.
    bit send_gaps;
    bit take_gaps;
    bit hold_output;

    cartridge_bank_switch_mapper u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Bank map: apply one item to the local state and return the translation
    // it produces. Mirroring in the result reflects the state after the item.
    // ------------------------------------------------------------------------
    function automatic out_item_t bank_map_step(input in_item_t a);
        out_item_t             res;
        int unsigned           v;
        int unsigned           slot;
        logic [PRG_CNT_W-1:0]  page;
        res = '0;
        case (a.op)
            OP_WRITE:
            begin
                if (a.addr == ADDR_CHR_PAIR0 || a.addr == ADDR_CHR_PAIR1)
                begin
                    // Pair select: masked to 7 bits, second page wraps.
                    if (chr_pages != 0)
                    begin
                        v    = int'(a.data & CHR_PAIR_MASK) % int'(chr_pages);
                        slot = (a.addr == ADDR_CHR_PAIR0) ? 0 : 2;
                        chr_sel[slot]     = CHR_PAGE_W'(v);
                        chr_sel[slot + 1] = CHR_PAGE_W'((v + 1) % int'(chr_pages));
                    end
                end
                else if (a.addr >= ADDR_CHR_ONE_LO && a.addr <= ADDR_CHR_ONE_HI)
                begin
                    if (chr_pages != 0)
                    begin
                        slot = 4 + int'(a.addr - ADDR_CHR_ONE_LO);
                        chr_sel[slot] = CHR_PAGE_W'(int'(a.data) % int'(chr_pages));
                    end
                end
                else if (a.addr == ADDR_MIRROR)
                begin
                    mirror_v = a.data[0];
                end
                else if (a.addr >= ADDR_PRG_LO && a.addr <= ADDR_PRG_HI)
                begin
                    if (prg_pages != 0)
                    begin
                        slot = int'(a.addr - ADDR_PRG_LO) >> 1;
                        prg_sel[slot] = PRG_CNT_W'(int'(a.data) % int'(prg_pages));
                    end
                end
            end
            OP_CPU:
            begin
                if (a.addr >= CPU_ROM_BASE)
                begin
                    slot = a.addr[14:13];
                    // Last slot is pinned to the final page, wrapping on a zero count.
                    page = (slot < PRG_SLOTS - 1) ? prg_sel[slot]
                                                  : PRG_CNT_W'(prg_pages - 9'd1);
                    res.rom_address = {page, a.addr[12:0]};
                    res.mapped      = 1'b1;
                end
            end
            OP_PPU:
            begin
                if (a.addr < PPU_CHR_TOP && chr_pages != 0)
                begin
                    slot = a.addr[12:10];
                    res.rom_address = ROM_W'({chr_sel[slot], a.addr[9:0]});
                    res.mapped      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res.vertical_mirroring = mirror_v;
        return res;
    endfunction

    function automatic in_item_t mk_access(input op_t op, input logic [ADDR_W-1:0] addr,
                                           input logic [DATA_W-1:0] data);
        in_item_t a;
        a.op   = op;
        a.addr = addr;
        a.data = data;
        return a;
    endfunction

    // Mostly well-formed traffic: bank register writes and in-window
    // translates, with a share of fully random items as noise.
    function automatic in_item_t random_access();
        in_item_t    a;
        int unsigned pick;
        pick   = $urandom_range(0, 99);
        a.data = DATA_W'($urandom);
        if (pick < 35)
        begin
            a.op   = OP_WRITE;
            a.addr = ADDR_CHR_PAIR0 + ADDR_W'($urandom_range(0, 15));
        end
        else if (pick < 60)
        begin
            a.op   = OP_CPU;
            a.addr = CPU_ROM_BASE | ADDR_W'($urandom_range(0, 16'h7FFF));
        end
        else if (pick < 85)
        begin
            a.op   = OP_PPU;
            a.addr = ADDR_W'($urandom_range(0, 16'h1FFF));
        end
        else
        begin
            a.op   = op_t'($urandom_range(0, 3));
            a.addr = ADDR_W'($urandom);
        end
        return a;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: optional idle gap, then hold the item until the block takes it.
    // Valid is left high on acceptance so that a back-to-back item never
    // sees valid dropped and raised in the same step.
    // ------------------------------------------------------------------------
    task automatic offer_access(input in_item_t a);
        int unsigned gap;
        gap = send_gaps ? $urandom_range(0, 4) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= a;
        do @(posedge clk); while (!in_ready);
        awaited_maps.push_back(bank_map_step(a));
    endtask

    // Drop valid and hold until every awaited translation has come back.
    // Every item yields a result, so an empty store means the block is idle.
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (awaited_maps.size() != 0);
    endtask

    // Write both page counts back to back; only called with the block idle.
    task automatic set_page_counts(input logic [PRG_CNT_W-1:0] prg,
                                   input logic [CHR_CNT_W-1:0] chr);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_PRG_COUNT;
        cfg_data  <= CFG_W'(prg);
        do @(posedge clk); while (!cfg_ready);
        // A new PRG count also reloads the third switchable slot.
        prg_pages  = prg;
        prg_sel[2] = PRG_CNT_W'(prg - 9'd2);
        cfg_index <= CFG_CHR_COUNT;
        cfg_data  <= CFG_W'(chr);
        do @(posedge clk); while (!cfg_ready);
        chr_pages  = chr;
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings: window edges, every write decode and the unused op.
    task automatic test_directed_decode();
        offer_access(mk_access(OP_CPU,   16'h8000, 8'h00));
        offer_access(mk_access(OP_CPU,   16'hFFFF, 8'hFF));
        offer_access(mk_access(OP_CPU,   16'h7FFF, 8'h00));
        offer_access(mk_access(OP_CPU,   16'hC123, 8'h00));
        offer_access(mk_access(OP_PPU,   16'h0000, 8'h00));
        offer_access(mk_access(OP_PPU,   16'h1FFF, 8'h00));
        offer_access(mk_access(OP_PPU,   16'h2000, 8'h00));
        // Pair write with the top bit set: masked, and the second page wraps.
        offer_access(mk_access(OP_WRITE, ADDR_CHR_PAIR0, 8'hFF));
        offer_access(mk_access(OP_WRITE, ADDR_CHR_PAIR1, 8'h83));
        offer_access(mk_access(OP_WRITE, 16'h7EF3, 8'hFE));
        offer_access(mk_access(OP_WRITE, ADDR_MIRROR, 8'hFF));
        offer_access(mk_access(OP_WRITE, ADDR_MIRROR, 8'hFE));
        offer_access(mk_access(OP_WRITE, 16'h7EFB, 8'hFF));
        offer_access(mk_access(OP_WRITE, 16'h7EFC, 8'h03));
        offer_access(mk_access(OP_WRITE, ADDR_PRG_HI, 8'h00));
        // Items that must change nothing.
        offer_access(mk_access(OP_WRITE, 16'h7EF7, 8'hFF));
        offer_access(mk_access(OP_WRITE, 16'h0000, 8'hFF));
        offer_access(mk_access(OP_SPARE, ADDR_CHR_PAIR0, 8'h55));
        offer_access(mk_access(OP_PPU,   16'h0C00, 8'h00));
        offer_access(mk_access(OP_CPU,   16'hA000, 8'h00));
        wait_results_drained();
    endtask

    // No CHR ROM, zero PRG count and a PRG count of one.
    task automatic test_page_count_corners();
        set_page_counts(9'd2, 11'd0);
        offer_access(mk_access(OP_WRITE, ADDR_CHR_ONE_LO, 8'h05));
        offer_access(mk_access(OP_PPU,   16'h0800, 8'h00));
        wait_results_drained();
        set_page_counts(9'd0, 11'd8);
        offer_access(mk_access(OP_WRITE, ADDR_PRG_LO, 8'h10));
        offer_access(mk_access(OP_CPU,   16'hE000, 8'h00));
        offer_access(mk_access(OP_CPU,   16'hC000, 8'h00));
        wait_results_drained();
        set_page_counts(9'd1, 11'd8);
        offer_access(mk_access(OP_CPU,   16'hE000, 8'h00));
        offer_access(mk_access(OP_CPU,   16'hC000, 8'h00));
        wait_results_drained();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the output register fills and the block stalls its input.
    task automatic test_output_backpressure();
        int i;
        send_gaps   = 1'b0;
        hold_output = 1'b1;
        for (i = 0; i < 12; i++)
            offer_access(random_access());
        wait_results_drained();
        send_gaps = 1'b1;
    endtask

    // Phases of random traffic under different page counts, extremes included.
    // A negative entry picks a random count in the legal range.
    task automatic test_random_traffic();
        int prg_plan [PHASES];
        int chr_plan [PHASES];
        int p;
        int i;
        logic [PRG_CNT_W-1:0] prg;
        logic [CHR_CNT_W-1:0] chr;
        prg_plan = '{2, 510, 3, -1, 1, -1, 510, 0, -1};
        chr_plan = '{8, 2040, 1, -1, 0, 255, 256, -1, 2040};
        for (p = 0; p < PHASES; p++)
        begin
            prg = (prg_plan[p] < 0) ? PRG_CNT_W'($urandom_range(2, 510))
                                    : PRG_CNT_W'(prg_plan[p]);
            chr = (chr_plan[p] < 0) ? CHR_CNT_W'($urandom_range(1, 2040))
                                    : CHR_CNT_W'(chr_plan[p]);
            set_page_counts(prg, chr);
            send_gaps = ($urandom_range(0, 3) != 0);
            take_gaps = ($urandom_range(0, 3) != 0);
            for (i = 0; i < ITEMS_A_PHASE; i++)
            begin
                offer_access(random_access());
                // Pause the sender now and then until everything is back.
                if (i == ITEMS_A_PHASE / 2 && p[0])
                    wait_results_drained();
            end
            wait_results_drained();
        end
        send_gaps = 1'b1;
        take_gaps = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall per item when gaps are enabled, plus the long hold on request.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_output)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end
            stall = take_gaps ? $urandom_range(0, 4) : 0;
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Compare each accepted result with the oldest awaited translation.
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n === 1'b1 && out_valid && out_ready)
        begin
            if (awaited_maps.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result rom_address %h mapped %0d mirroring %0d",
                             out_item.rom_address, out_item.mapped,
                             out_item.vertical_mirroring);
            end
            else
            begin
                want = awaited_maps.pop_front();
                if (out_item.rom_address !== want.rom_address
                    || out_item.mapped !== want.mapped
                    || out_item.vertical_mirroring !== want.vertical_mirroring)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: rom_address exp %h got %h, mapped exp %0d got %0d, %s",
                                 want.rom_address, out_item.rom_address, want.mapped,
                                 out_item.mapped,
                                 $sformatf("mirroring exp %0d got %0d",
                                           want.vertical_mirroring,
                                           out_item.vertical_mirroring));
                end
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("cartridge_bank_switch_mapper regression: fail");
            $finish;
        end
    end

    initial
    begin : main_sequence
        int i;
        // Drive every input to a known value before reset.
        in_valid       = 1'b0;
        in_item        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        rst_n          = 1'b0;
        send_gaps      = 1'b1;
        take_gaps      = 1'b1;
        hold_output    = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;

        // Bank map as it stands after reset.
        prg_pages  = PRG_COUNT_RESET;
        chr_pages  = CHR_COUNT_RESET;
        for (i = 0; i < CHR_SLOTS; i++)
            chr_sel[i] = CHR_PAGE_W'(i);
        prg_sel[0] = 9'd0;
        prg_sel[1] = 9'd1;
        prg_sel[2] = PRG_CNT_W'(PRG_COUNT_RESET - 9'd2);
        mirror_v   = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_decode();
        test_page_count_corners();
        test_output_backpressure();
        test_random_traffic();

        // Let any stray result surface before judging the run.
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        mismatch_count += awaited_maps.size();

        if (mismatch_count == 0)
            $display("cartridge_bank_switch_mapper regression: pass");
        else
            $display("cartridge_bank_switch_mapper regression: fail");
        $finish;
    end

endmodule

// File: cartridge_bank_switch_mapper.f
hdl/cbsm_pkg.sv
hdl/cbsm_rem_unit.sv
hdl/cartridge_bank_switch_mapper.sv
sim/cartridge_bank_switch_mapper_tb.sv
